FILE: design/irsp_pkg.sv
// Shared types and constants of the IMU record stream parser.
`timescale 1ns / 1ps

package irsp_pkg;

	// Record type bytes.
	localparam logic [7:0] TYPE_SKIP   = 8'h21;
	localparam logic [7:0] TYPE_MOTION = 8'h22;

	// Record kinds tracked by the front end.
	localparam logic [1:0] KIND_PLAIN  = 2'd0;
	localparam logic [1:0] KIND_SKIP   = 2'd1;
	localparam logic [1:0] KIND_MOTION = 2'd2;

	// Byte positions inside a record.
	localparam int         POS_W           = 4;
	localparam logic [3:0] POS_TYPE        = 4'd0;
	localparam logic [3:0] POS_BUTTON      = 4'd1;
	localparam logic [3:0] POS_PAYLOAD     = 4'd2;
	localparam logic [3:0] POS_SKIP_LAST   = 4'd3;
	localparam logic [3:0] POS_MOTION_LAST = 4'd13;

	// Stored motion payload bytes (all but the final one).
	localparam int PAYLOAD_DEPTH = 11;
	localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_DEPTH);

	// Button byte value that means pressed.
	localparam logic [7:0] BUTTON_DOWN = 8'd1;

	// Command queue between front and back end.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Command codes.
	localparam logic [1:0] CMD_RELOAD = 2'd0;
	localparam logic [1:0] CMD_BUTTON = 2'd1;
	localparam logic [1:0] CMD_STORE  = 2'd2;
	localparam logic [1:0] CMD_FINISH = 2'd3;

	typedef struct packed {
		logic [1:0]               code;
		logic [PAYLOAD_IDX_W-1:0] idx;
		logic [7:0]               data;
	} cmd_t;

endpackage

FILE: design/imu_record_stream_parser_top.sv
// Top level of the IMU record stream parser.
`timescale 1ns / 1ps

// The parser takes one notification byte per cycle while in_stall is low
// and, on the last byte of every complete motion record (type 0x22) that
// is not discarded, delivers one frame of six signed 16-bit values with
// the button state and a button-changed flag. Records of type 0x21 skip
// two bytes, other types are header only, and any record cut short by the
// packet end is dropped. A stream start request reloads the discard count
// from warmup_frames (write it only while the parser is idle; it takes
// effect at the next stream start). Throughput is one request per cycle
// while in_stall is low. A frame passes through the front end's command
// queue, then the back end's output register. While a frame waits on a
// stalled output, requests keep flowing until the final command of the next
// frame reaches the head of the two-entry command queue with one more
// command behind it; then in_stall rises until the output drains.

module imu_record_stream_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         warmup_frames,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic [7:0]         data_byte,
	input  logic               last_in_packet,
	// frame channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] gyro_x,
	output logic signed [15:0] gyro_y,
	output logic signed [15:0] gyro_z,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic               button_pressed,
	output logic               button_changed
);

	logic           accept;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;
	irsp_pkg::cmd_t push_cmd;
	irsp_pkg::cmd_t head_cmd;

	// the register write is always taken
	assign cfg_ready = 1'b1;

	// hold requests while the command queue is full
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	irsp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.operation      (operation),
		.data_byte      (data_byte),
		.last_in_packet (last_in_packet),
		.push           (push),
		.cmd            (push_cmd)
	);

	irsp_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.not_empty (q_not_empty),
		.full      (q_full),
		.head      (head_cmd)
	);

	irsp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_valid && cfg_ready),
		.cfg_data       (warmup_frames),
		.cmd_valid      (q_not_empty),
		.cmd            (head_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.gyro_x         (gyro_x),
		.gyro_y         (gyro_y),
		.gyro_z         (gyro_z),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.button_pressed (button_pressed),
		.button_changed (button_changed)
	);

endmodule

FILE: design/irsp_front.sv
// Front end: tracks record position and turns bytes into back-end commands.
`timescale 1ns / 1ps

module irsp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              operation,
	input  logic [7:0]        data_byte,
	input  logic              last_in_packet,
	output logic              push,
	output irsp_pkg::cmd_t    cmd
);

	logic [irsp_pkg::POS_W-1:0] pos_q, pos_d;
	logic [1:0]                 kind_q, kind_d;
	logic                       done;

	always_comb begin
		pos_d    = pos_q;
		kind_d   = kind_q;
		done     = 1'b0;
		push     = 1'b0;
		cmd.code = irsp_pkg::CMD_RELOAD;
		cmd.idx  = '0;
		cmd.data = data_byte;
		if (operation) begin
			push   = 1'b1;
			pos_d  = irsp_pkg::POS_TYPE;
			kind_d = irsp_pkg::KIND_PLAIN;
		end else begin
			if (pos_q == irsp_pkg::POS_TYPE) begin
				if (data_byte == irsp_pkg::TYPE_SKIP)
					kind_d = irsp_pkg::KIND_SKIP;
				else if (data_byte == irsp_pkg::TYPE_MOTION)
					kind_d = irsp_pkg::KIND_MOTION;
				else
					kind_d = irsp_pkg::KIND_PLAIN;
				pos_d = irsp_pkg::POS_BUTTON;
			end else if (pos_q == irsp_pkg::POS_BUTTON) begin
				if (kind_q == irsp_pkg::KIND_MOTION) begin
					push     = 1'b1;
					cmd.code = irsp_pkg::CMD_BUTTON;
					cmd.data = {7'd0, data_byte == irsp_pkg::BUTTON_DOWN};
				end
				if (kind_q == irsp_pkg::KIND_PLAIN)
					done = 1'b1;
				else
					pos_d = irsp_pkg::POS_PAYLOAD;
			end else if (kind_q == irsp_pkg::KIND_SKIP) begin
				if (pos_q >= irsp_pkg::POS_SKIP_LAST)
					done = 1'b1;
				else
					pos_d = pos_q + 1'b1;
			end else if (kind_q == irsp_pkg::KIND_MOTION
					&& pos_q < irsp_pkg::POS_MOTION_LAST) begin
				push     = 1'b1;
				cmd.code = irsp_pkg::CMD_STORE;
				cmd.idx  = pos_q - irsp_pkg::POS_PAYLOAD;
				pos_d    = pos_q + 1'b1;
			end else if (kind_q == irsp_pkg::KIND_MOTION) begin
				push     = 1'b1;
				cmd.code = irsp_pkg::CMD_FINISH;
				done     = 1'b1;
			end else begin
				done = 1'b1;
			end
			// a packet end drops whatever record is in progress
			if (done || last_in_packet) begin
				pos_d  = irsp_pkg::POS_TYPE;
				kind_d = irsp_pkg::KIND_PLAIN;
			end
		end
		push = push & accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= irsp_pkg::POS_TYPE;
			kind_q <= irsp_pkg::KIND_PLAIN;
		end else if (accept) begin
			pos_q  <= pos_d;
			kind_q <= kind_d;
		end
	end

endmodule

FILE: design/irsp_cmd_queue.sv
// Short command queue between the front and back end.
`timescale 1ns / 1ps

module irsp_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  irsp_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           not_empty,
	output logic           full,
	output irsp_pkg::cmd_t head
);

	irsp_pkg::cmd_t                   mem_q [irsp_pkg::QUEUE_DEPTH];
	logic [irsp_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [irsp_pkg::QUEUE_CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == irsp_pkg::QUEUE_CNT_W'(irsp_pkg::QUEUE_DEPTH));
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: design/irsp_back.sv
// Back end: holds payload and discard state, builds frames into the output register.
`timescale 1ns / 1ps

module irsp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [7:0]         cfg_data,
	input  logic               cmd_valid,
	input  irsp_pkg::cmd_t     cmd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] gyro_x,
	output logic signed [15:0] gyro_y,
	output logic signed [15:0] gyro_z,
	output logic signed [15:0] accel_x,
	output logic signed [15:0] accel_y,
	output logic signed [15:0] accel_z,
	output logic               button_pressed,
	output logic               button_changed
);

	logic [7:0] warmup_frames_q;
	logic [7:0] discard_left_q;
	logic       frame_button_q;
	logic       last_button_q;
	logic       out_valid_q;
	logic [7:0] payload_q [irsp_pkg::PAYLOAD_DEPTH];
	logic       emit;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = (cmd.code == irsp_pkg::CMD_FINISH) && (discard_left_q == 8'd0);
	assign pop      = cmd_valid && (!emit || out_free);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (pop && cmd.code == irsp_pkg::CMD_STORE)
			payload_q[cmd.idx] <= cmd.data;
		if (pop && emit) begin
			gyro_x         <= {payload_q[1], payload_q[0]};
			gyro_y         <= {payload_q[3], payload_q[2]};
			gyro_z         <= {payload_q[5], payload_q[4]};
			accel_x        <= {payload_q[7], payload_q[6]};
			accel_y        <= {payload_q[9], payload_q[8]};
			accel_z        <= {cmd.data, payload_q[10]};
			button_pressed <= frame_button_q;
			button_changed <= frame_button_q ^ last_button_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warmup_frames_q <= 8'd0;
			discard_left_q  <= 8'd0;
			frame_button_q  <= 1'b0;
			last_button_q   <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_write)
				warmup_frames_q <= cfg_data;
			if (pop) begin
				case (cmd.code)
					irsp_pkg::CMD_RELOAD: begin
						discard_left_q <= warmup_frames_q;
					end
					irsp_pkg::CMD_BUTTON: begin
						frame_button_q <= cmd.data[0];
					end
					irsp_pkg::CMD_FINISH: begin
						if (emit)
							last_button_q <= frame_button_q;
						else
							discard_left_q <= discard_left_q - 8'd1;
					end
					default: begin
					end
				endcase
			end
			if (pop && emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: bench/tb_imu_record_stream_parser_top.sv
// Self-checking regression bench for the IMU record stream parser.
`timescale 1ns / 1ps

module tb_imu_record_stream_parser_top;

	// Run length and pacing.
	localparam int CYCLE_LIMIT    = 300000;
	localparam int PHASE_REQUESTS = 180;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 150;

	// One decoded motion frame, in port order.
	typedef struct packed {
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic signed [15:0] gz;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		logic               pressed;
		logic               changed;
	} frame_t;

	// One row of the directed table: a request plus, where it is obvious,
	// the frame it must produce.
	typedef struct packed {
		bit         op;
		logic [7:0] b;
		bit         last;
		bit         typed;
		frame_t     want;
	} stim_row_t;

	localparam frame_t NO_FRAME = '0;
	// First frame after reset: signed extremes and edge values on gyro/accel,
	// button down, and the change flag set because the last emitted state is "not pressed".
	localparam frame_t EXTREME_FRAME = {16'h8000, 16'h7FFF, 16'hFFFF,
		16'h0000, 16'h0001, 16'h7F80, 1'b1, 1'b1};

	// Directed table. Stream start ignores its byte and flag; then one full
	// motion record, a skip record, a header-only record, a lone type byte
	// cut by the packet end, and a skip record cut short.
	stim_row_t directed_rows [24] = '{
		'{1'b1, 8'hFF, 1'b1, 1'b0, NO_FRAME},
		'{1'b0, 8'h22, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h01, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h80, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h7F, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'hFF, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h01, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h80, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h7F, 1'b1, 1'b1, EXTREME_FRAME},
		'{1'b0, 8'h21, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'hAA, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h55, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h00, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h01, 1'b1, 1'b0, NO_FRAME},
		'{1'b0, 8'h22, 1'b1, 1'b0, NO_FRAME},
		'{1'b0, 8'h21, 1'b0, 1'b0, NO_FRAME},
		'{1'b0, 8'h03, 1'b1, 1'b0, NO_FRAME}
	};

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         warmup_frames;
	logic               in_valid;
	logic               in_stall;
	logic               operation;
	logic [7:0]         data_byte;
	logic               last_in_packet;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic               button_pressed;
	logic               button_changed;

	// Parser image kept by the bench.
	logic [7:0] discard_setting;
	logic [7:0] discards_left;
	logic [3:0] rec_pos;
	logic [1:0] rec_kind;
	logic       rec_button;
	logic       shown_button;
	logic [7:0] motion_bytes [0:10];

	frame_t frames_due [$];
	int     requests_sent;
	int     mismatch_count;
	int     cycle_count;
	int     hold_requests;
	bit     calm;

	imu_record_stream_parser_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.warmup_frames (warmup_frames),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.operation     (operation),
		.data_byte     (data_byte),
		.last_in_packet(last_in_packet),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.gyro_x        (gyro_x),
		.gyro_y        (gyro_y),
		.gyro_z        (gyro_z),
		.accel_x       (accel_x),
		.accel_y       (accel_y),
		.accel_z       (accel_z),
		.button_pressed(button_pressed),
		.button_changed(button_changed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case a handshake never completes.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("imu_record_stream_parser_top regression: fail");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	// Roll for an idle cycle on either side; none while the calm stretch runs.
	function automatic bit idle_now();
		return !calm && ($urandom_range(0, 99) < 7);
	endfunction

	// Advance the parser image by one request. Return 1 and the frame when
	// the request completes a motion record that is not discarded.
	function automatic bit decode_request(input bit op, input logic [7:0] b,
			input bit last, output frame_t f);
		bit done;
		done = 1'b0;
		f = NO_FRAME;
		// Stream start: reload the discard count, restart, keep the button.
		if (op) begin
			discards_left = discard_setting;
			rec_pos = irsp_pkg::POS_TYPE;
			rec_kind = irsp_pkg::KIND_PLAIN;
			return 1'b0;
		end
		if (rec_pos == irsp_pkg::POS_TYPE) begin
			rec_kind = (b == irsp_pkg::TYPE_SKIP) ? irsp_pkg::KIND_SKIP :
				(b == irsp_pkg::TYPE_MOTION) ? irsp_pkg::KIND_MOTION :
				irsp_pkg::KIND_PLAIN;
			rec_pos = irsp_pkg::POS_BUTTON;
		end else if (rec_pos == irsp_pkg::POS_BUTTON) begin
			rec_button = (b == irsp_pkg::BUTTON_DOWN);
			if (rec_kind == irsp_pkg::KIND_PLAIN)
				done = 1'b1;
			else
				rec_pos = irsp_pkg::POS_PAYLOAD;
		end else if (rec_kind == irsp_pkg::KIND_SKIP) begin
			if (rec_pos >= irsp_pkg::POS_SKIP_LAST)
				done = 1'b1;
			else
				rec_pos = rec_pos + 4'd1;
		end else if (rec_kind == irsp_pkg::KIND_MOTION
				&& rec_pos < irsp_pkg::POS_MOTION_LAST) begin
			motion_bytes[rec_pos - irsp_pkg::POS_PAYLOAD] = b;
			rec_pos = rec_pos + 4'd1;
		end else if (rec_kind == irsp_pkg::KIND_MOTION) begin
			done = 1'b1;
			if (discards_left != 8'd0) begin
				// Discarded frame: count it down, leave the button history alone.
				discards_left = discards_left - 8'd1;
			end else begin
				f.gx = {motion_bytes[1], motion_bytes[0]};
				f.gy = {motion_bytes[3], motion_bytes[2]};
				f.gz = {motion_bytes[5], motion_bytes[4]};
				f.ax = {motion_bytes[7], motion_bytes[6]};
				f.ay = {motion_bytes[9], motion_bytes[8]};
				f.az = {b, motion_bytes[10]};
				f.pressed = rec_button;
				f.changed = (rec_button != shown_button);
				shown_button = rec_button;
				done = 1'b1;
				if (last || done) begin
					rec_pos = irsp_pkg::POS_TYPE;
					rec_kind = irsp_pkg::KIND_PLAIN;
				end
				return 1'b1;
			end
		end else begin
			done = 1'b1;
		end
		// End of record or end of packet: expect a type byte next.
		if (done || last) begin
			rec_pos = irsp_pkg::POS_TYPE;
			rec_kind = irsp_pkg::KIND_PLAIN;
		end
		return 1'b0;
	endfunction

	// Offer one request, hold it until accepted, then log its expected frame.
	// A typed expectation from the directed table overrides the prediction.
	task automatic send_request(input bit op, input logic [7:0] b, input bit last,
			input bit typed = 1'b0, input frame_t want = NO_FRAME);
		frame_t predicted;
		bit     produced;
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		data_byte      <= b;
		last_in_packet <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		requests_sent++;
		produced = decode_request(op, b, last, predicted);
		if (produced || typed)
			frames_due.insert(frames_due.size(), typed ? want : predicted);
	endtask

	// Emit one random record: mostly well-formed motion records with random
	// payload, plus skip and header-only records, stream starts, raw noise,
	// and records cut short by an early packet end.
	task automatic send_record();
		logic [7:0] rec [0:13];
		int         len;
		int         cut;
		int         roll;
		bit         end_flag;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			send_request(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
			return;
		end
		foreach (rec[k])
			rec[k] = 8'($urandom);
		if (roll < 72) begin
			len = 14;
			rec[0] = irsp_pkg::TYPE_MOTION;
		end else if (roll < 82) begin
			len = 4;
			rec[0] = irsp_pkg::TYPE_SKIP;
		end else if (roll < 90) begin
			len = 2;
		end else begin
			len = $urandom_range(1, 6);
		end
		// Bias the button byte toward 0 and 1 so that changes happen often.
		if (roll < 90) begin
			case ($urandom_range(0, 3))
				0: rec[1] = 8'd0;
				1, 2: rec[1] = irsp_pkg::BUTTON_DOWN;
				default: ;
			endcase
		end
		cut = ($urandom_range(0, 99) < 8) ? $urandom_range(0, len - 1) : len - 1;
		for (int k = 0; k <= cut; k++) begin
			if (k != cut)
				end_flag = 1'b0;
			else if (cut < len - 1)
				end_flag = 1'b1;
			else
				end_flag = ($urandom_range(0, 99) < 40);
			send_request(1'b0, rec[k], end_flag);
		end
	endtask

	// Drop valid and wait until every expected frame has arrived, then give
	// the pipeline time to finish work that produces no frame.
	task automatic drain();
		in_valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_discard(input logic [7:0] value);
		cfg_valid     <= 1'b1;
		warmup_frames <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		discard_setting = value;
	endtask

	// Receiver: random stalls, plus a long hold whenever the stimulus asks
	// for one, so the command queue fills and the input stalls.
	initial begin : receiver
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_now();
			end
		end
	end

	// Compare every accepted frame with the oldest expectation.
	always @(posedge clk) begin : frame_check
		frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				report_mismatch("frame delivered with none expected");
			end else begin
				want = frames_due.pop_front();
				if (gyro_x !== want.gx)
					report_mismatch($sformatf("gyro_x %0d, want %0d", gyro_x, want.gx));
				if (gyro_y !== want.gy)
					report_mismatch($sformatf("gyro_y %0d, want %0d", gyro_y, want.gy));
				if (gyro_z !== want.gz)
					report_mismatch($sformatf("gyro_z %0d, want %0d", gyro_z, want.gz));
				if (accel_x !== want.ax)
					report_mismatch($sformatf("accel_x %0d, want %0d", accel_x, want.ax));
				if (accel_y !== want.ay)
					report_mismatch($sformatf("accel_y %0d, want %0d", accel_y, want.ay));
				if (accel_z !== want.az)
					report_mismatch($sformatf("accel_z %0d, want %0d", accel_z, want.az));
				if (button_pressed !== want.pressed)
					report_mismatch($sformatf("button_pressed %0b, want %0b",
						button_pressed, want.pressed));
				if (button_changed !== want.changed)
					report_mismatch($sformatf("button_changed %0b, want %0b",
						button_changed, want.changed));
			end
		end
	end

	initial begin : stimulus
		int         phase;
		int         phase_base;
		logic [7:0] setting;
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		warmup_frames  <= 8'd0;
		in_valid       <= 1'b0;
		operation      <= 1'b0;
		data_byte      <= 8'd0;
		last_in_packet <= 1'b0;
		calm = 1'b0;
		hold_requests = 0;

		// Parser image after reset: nothing pressed, no discards, idle.
		discard_setting = 8'd0;
		discards_left = 8'd0;
		rec_pos = irsp_pkg::POS_TYPE;
		rec_kind = irsp_pkg::KIND_PLAIN;
		rec_button = 1'b0;
		shown_button = 1'b0;
		foreach (motion_bytes[k])
			motion_bytes[k] = 8'd0;

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, with the register at its reset value.
		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].b,
				directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);

		// Random phases, one discard setting each: the top extreme first,
		// then zero, small counts, and random small counts.
		for (phase = 0; phase < 6; phase++) begin
			drain();
			case (phase)
				0: setting = 8'd255;
				1: setting = 8'd0;
				2: setting = 8'd1;
				3: setting = 8'd2;
				default: setting = 8'($urandom_range(0, 3));
			endcase
			write_discard(setting);
			// Usually start the stream so the setting applies at once; otherwise
			// the old count stays in force until a start comes along. The hold
			// phase always starts it so that frames flow and back up.
			if (phase == 1 || $urandom_range(0, 3) != 0)
				send_request(1'b1, 8'($urandom), 1'($urandom_range(0, 1)));
			// Phase 1: long output hold while requests keep coming.
			if (phase == 1)
				hold_requests++;
			// Phase 2: no idle cycles on either side.
			calm = (phase == 2);
			phase_base = requests_sent;
			while (requests_sent - phase_base < PHASE_REQUESTS)
				send_record();
			calm = 1'b0;
		end

		drain();
		if (mismatch_count == 0)
			$display("imu_record_stream_parser_top regression: pass");
		else
			$display("imu_record_stream_parser_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
design/irsp_pkg.sv
design/irsp_front.sv
design/irsp_cmd_queue.sv
design/irsp_back.sv
design/imu_record_stream_parser_top.sv
bench/tb_imu_record_stream_parser_top.sv
